// File: rtl/gmte_pkg.sv
// Shared types and constants for the move time estimator.
// No dependencies; gmte_lane, gmte_merge and the top level import this package.
`default_nettype none
package gmte_pkg;
   localparam int unsigned WordWidth  = 32;
   localparam int unsigned TotalWidth = 48;

   localparam logic [2:0] MODE_NOP      = 3'd0;
   localparam logic [2:0] MODE_MOVE     = 3'd1;
   localparam logic [2:0] MODE_SET_ACC  = 3'd2;
   localparam logic [2:0] MODE_DWELL_S  = 3'd3;
   localparam logic [2:0] MODE_DWELL_MS = 3'd4;

   localparam logic [WordWidth-1:0]  DEFAULT_ACCEL_RESET = 32'd262144000;
   localparam logic [WordWidth-1:0]  MS_PER_SECOND       = 32'd1000;
   // x/1000 == (x * MS_RECIP) >> MS_SHIFT for every 32-bit x
   localparam logic [WordWidth-1:0]  MS_RECIP            = 32'd274877907;
   localparam int unsigned           MS_SHIFT            = 38;
   localparam logic [WordWidth-1:0]  WORD_MAX            = '1;
   localparam logic [TotalWidth-1:0] TOTAL_MAX           = '1;

   // Work handed to one lane: a leg time, or a plain division of len by 1000.
   typedef struct packed {
      logic                 op_div;
      logic [WordWidth-1:0] len;
      logic [WordWidth-1:0] feed;
      logic [WordWidth-1:0] acc;
   } lane_req_type;

   // What the merge stage needs to finish one transaction.
   typedef struct packed {
      logic                 need0;
      logic                 need1;
      logic [WordWidth-1:0] imm;
      logic                 flag;
   } item_ctl_type;
endpackage
`default_nettype wire

// File: rtl/gmte_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on nothing but its parameters.
`default_nettype none
module gmte_div #(
   parameter int unsigned NW = 54,
   parameter int unsigned DW = 38
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [NW-1:0] numer,
   input  wire logic [DW-1:0] denom,
   output logic               done,
   output logic [NW-1:0]      quot
);
   localparam int unsigned CW = $clog2(NW + 1);

   logic          busy_ff, busy_in, done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] rem_ff, rem_in, den_ff, den_in;
   logic [NW-1:0] quot_ff, quot_in;
   logic [DW:0]   shifted, diff;
   logic          ge;

   always_comb begin
      shifted = {rem_ff, quot_ff[NW-1]};
      diff    = shifted - {1'b0, den_ff};
      ge      = shifted >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(NW);
         rem_in  = '0;
         den_in  = denom;
         quot_in = numer;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[DW-1:0] : shifted[DW-1:0];
         quot_in = {quot_ff[NW-2:0], ge};
         cnt_in  = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;
endmodule
`default_nettype wire

// File: rtl/gmte_lane.sv
// One timing lane: products for the cruise test, then one or two divisions; a
// millisecond dwell uses a reciprocal multiply. Depends on gmte_pkg and gmte_div.
`default_nettype none
module gmte_lane #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire gmte_pkg::lane_req_type req,
   output logic                       done,
   output logic [gmte_pkg::WordWidth-1:0] result
);
   import gmte_pkg::*;

   localparam int unsigned DW = WordWidth + 6;
   localparam int unsigned NW = DW + FRAC_BITS;
   localparam int unsigned PW = 2 * WordWidth;
   localparam int unsigned XW = PW + 12;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_MUL  = 6'b000010,
      S_CMP  = 6'b000100,
      S_DIV1 = 6'b001000,
      S_DIV2 = 6'b010000,
      S_FIN  = 6'b100000
   } lane_state_type;

   lane_state_type        state_ff, state_in;
   lane_req_type          req_ff, req_in;
   logic [PW-1:0]         p1_ff, p1_in, sq_ff, sq_in;
   logic                  ok_ff, ok_in;
   logic [NW-1:0]         cruise_ff, cruise_in;
   logic [WordWidth-1:0]  res_ff, res_in;
   logic                  div_start, div_done;
   logic [NW-1:0]         div_numer, div_quot;
   logic [DW-1:0]         div_denom, len60, acc60;
   logic [XW-1:0]         p2;
   logic [NW:0]           tsum;

   gmte_div #(.NW(NW), .DW(DW)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .numer(div_numer), .denom(div_denom), .done(div_done), .quot(div_quot)
   );

   always_comb begin
      len60 = ({6'b0, req_ff.len} << 6) - ({6'b0, req_ff.len} << 2);
      acc60 = ({6'b0, req_ff.acc} << 6) - ({6'b0, req_ff.acc} << 2);
      // len*acc*3600 with 3600 = 4096 - 512 + 16
      p2 = ({12'b0, p1_ff} << 12) - ({12'b0, p1_ff} << 9) + ({12'b0, p1_ff} << 4);
      tsum = {1'b0, cruise_ff} + {1'b0, div_quot};
      state_in  = state_ff;
      req_in    = req_ff;
      p1_in     = p1_ff;
      sq_in     = sq_ff;
      ok_in     = ok_ff;
      cruise_in = cruise_ff;
      res_in    = res_ff;
      div_start = 1'b0;
      div_numer = {len60, {FRAC_BITS{1'b0}}};
      div_denom = {6'b0, req_ff.feed};
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in   = req;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            p1_in = PW'(req_ff.len) * PW'(req_ff.op_div ? MS_RECIP : req_ff.acc);
            sq_in = PW'(req_ff.feed) * PW'(req_ff.feed);
            if (req_ff.op_div) begin
               res_in   = WordWidth'(p1_in >> MS_SHIFT);
               state_in = S_FIN;
            end else begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            ok_in     = p2 >= {12'b0, sq_ff};
            div_start = 1'b1;
            state_in  = S_DIV1;
         end
         S_DIV1: begin
            if (div_done) begin
               cruise_in = div_quot;
               if (ok_ff) begin
                  div_start = 1'b1;
                  div_numer = {6'b0, req_ff.feed, {FRAC_BITS{1'b0}}};
                  div_denom = acc60;
                  state_in  = S_DIV2;
               end else begin
                  res_in   = (div_quot > NW'(WORD_MAX)) ? WORD_MAX : div_quot[WordWidth-1:0];
                  state_in = S_FIN;
               end
            end
         end
         S_DIV2: begin
            if (div_done) begin
               res_in   = (tsum > (NW+1)'(WORD_MAX)) ? WORD_MAX : tsum[WordWidth-1:0];
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      req_ff    <= req_in;
      p1_ff     <= p1_in;
      sq_ff     <= sq_in;
      ok_ff     <= ok_in;
      cruise_ff <= cruise_in;
      res_ff    <= res_in;
   end

   assign done   = (state_ff == S_FIN);
   assign result = res_ff;
endmodule
`default_nettype wire

// File: rtl/gmte_merge.sv
// Merge stage: collects lane results, sums the item, updates the total and
// holds the response register. Depends on gmte_pkg.
`default_nettype none
module gmte_merge (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire gmte_pkg::item_ctl_type        ctl,
   input  wire logic                          done0,
   input  wire logic [gmte_pkg::WordWidth-1:0] res0,
   input  wire logic                          done1,
   input  wire logic [gmte_pkg::WordWidth-1:0] res1,
   output logic                               busy,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [gmte_pkg::TotalWidth-1:0]    rsp_total_time,
   output logic [gmte_pkg::WordWidth-1:0]     rsp_item_time,
   output logic                               rsp_zero_speed
);
   import gmte_pkg::*;

   logic                  pend_ff, pend_in, got0_ff, got0_in, got1_ff, got1_in;
   logic                  vld_ff, vld_in, zs_ff, zs_in;
   item_ctl_type          ctl_ff, ctl_in;
   logic [WordWidth-1:0]  r0_ff, r0_in, r1_ff, r1_in, it_ff, it_in, item;
   logic [TotalWidth-1:0] tot_ff, tot_in, out_ff, out_in;
   logic [WordWidth+1:0]  isum;
   logic [TotalWidth:0]   tsum;
   logic                  finish;

   always_comb begin
      isum = {2'b0, ctl_ff.imm} + (ctl_ff.need0 ? {2'b0, r0_ff} : '0)
           + (ctl_ff.need1 ? {2'b0, r1_ff} : '0);
      item = (isum > (WordWidth+2)'(WORD_MAX)) ? WORD_MAX : isum[WordWidth-1:0];
      tsum = {1'b0, tot_ff} + (TotalWidth+1)'(item);
      finish = pend_ff && (got0_ff || !ctl_ff.need0) && (got1_ff || !ctl_ff.need1)
             && (!vld_ff || rsp_ready);
      pend_in = pend_ff;
      got0_in = got0_ff || done0;
      got1_in = got1_ff || done1;
      r0_in   = done0 ? res0 : r0_ff;
      r1_in   = done1 ? res1 : r1_ff;
      ctl_in  = ctl_ff;
      vld_in  = vld_ff && !rsp_ready;
      tot_in  = tot_ff;
      out_in  = out_ff;
      it_in   = it_ff;
      zs_in   = zs_ff;
      if (start) begin
         pend_in = 1'b1;
         got0_in = 1'b0;
         got1_in = 1'b0;
         ctl_in  = ctl;
      end else if (finish) begin
         pend_in = 1'b0;
         vld_in  = 1'b1;
         tot_in  = tsum[TotalWidth] ? TOTAL_MAX : tsum[TotalWidth-1:0];
         out_in  = tot_in;
         it_in   = item;
         zs_in   = ctl_ff.flag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         got0_ff <= 1'b0;
         got1_ff <= 1'b0;
         vld_ff  <= 1'b0;
         tot_ff  <= '0;
      end else begin
         pend_ff <= pend_in;
         got0_ff <= got0_in;
         got1_ff <= got1_in;
         vld_ff  <= vld_in;
         tot_ff  <= tot_in;
      end
      ctl_ff <= ctl_in;
      r0_ff  <= r0_in;
      r1_ff  <= r1_in;
      out_ff <= out_in;
      it_ff  <= it_in;
      zs_ff  <= zs_in;
   end

   assign busy           = pend_ff;
   assign rsp_valid      = vld_ff;
   assign rsp_total_time = out_ff;
   assign rsp_item_time  = it_ff;
   assign rsp_zero_speed = zs_ff;
endmodule
`default_nettype wire

// File: rtl/gcode_move_time_estimator_top.sv
// Move time estimator: top level with two timing lanes and a merge stage.
// Depends on gmte_pkg, gmte_lane, gmte_merge.
//
// Usage:
//   req_* carries one decoded command per transaction (valid/ready).
//   rsp_* returns exactly one result per command: running total, time
//   added by this command and the zero-feed flag (valid/ready).
//   csr_wr_en/csr_wr_data load the default acceleration; write only idle.
// Sequencing:
//   One command at a time. A move runs both legs in parallel lanes; each
//   lane forms its products, runs the cruise test and then one or two
//   serial divisions of 38+FRAC_BITS quotient bits each. A millisecond
//   dwell uses a reciprocal multiply in lane 0; other commands need no
//   lane. The next command can be accepted once the response is registered.
// Reset:
//   Clears the total and stored acceleration; default acceleration
//   returns to 262144000 (4000.0 in Q16.16).
// Stall:
//   The response register holds while rsp_ready is low. One new command
//   is accepted meanwhile; its result waits in the merge stage and the
//   input stalls until the held response is taken.
`default_nettype none
module gcode_move_time_estimator_top #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [31:0] csr_wr_data,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_mode,
   input  wire logic [31:0] req_planar_distance,
   input  wire logic signed [31:0] req_extruder_distance,
   input  wire logic signed [31:0] req_vertical_distance,
   input  wire logic [31:0] req_feed_rate,
   input  wire logic [31:0] req_argument,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [47:0]      rsp_total_time,
   output logic [31:0]      rsp_item_time,
   output logic             rsp_zero_speed
);
   import gmte_pkg::*;

   logic [WordWidth-1:0] dacc_ff, dacc_in, cacc_ff, cacc_in;
   logic [WordWidth-1:0] acc, ext_mag, vert_mag;
   logic                 accept, busy, move, ms, done0, done1;
   lane_req_type         lreq0, lreq1;
   item_ctl_type         ctl;
   logic [WordWidth-1:0] res0, res1;

   assign req_ready = !busy;
   assign accept    = req_valid && req_ready;

   always_comb begin
      ext_mag  = req_extruder_distance[31] ? WordWidth'(-req_extruder_distance)
                                           : WordWidth'(req_extruder_distance);
      vert_mag = req_vertical_distance[31] ? WordWidth'(-req_vertical_distance)
                                           : WordWidth'(req_vertical_distance);
      acc = (cacc_ff != '0) ? cacc_ff : dacc_ff;
      if (acc == '0) begin
         acc = WordWidth'(1);
      end
      move = (req_mode == MODE_MOVE) && (req_feed_rate != '0);
      ms   = (req_mode == MODE_DWELL_MS);
      lreq0.op_div = ms;
      lreq0.len    = ms ? req_argument
                        : ((req_planar_distance != '0) ? req_planar_distance : ext_mag);
      lreq0.feed   = req_feed_rate;
      lreq0.acc    = acc;
      lreq1.op_div = 1'b0;
      lreq1.len    = vert_mag;
      lreq1.feed   = req_feed_rate;
      lreq1.acc    = acc;
      ctl.need0 = move || ms;
      ctl.need1 = move;
      ctl.flag  = (req_mode == MODE_MOVE) && (req_feed_rate == '0);
      case (req_mode)
         MODE_MOVE:    ctl.imm = ctl.flag ? WORD_MAX : '0;
         MODE_DWELL_S: ctl.imm = req_argument;
         default:      ctl.imm = '0;
      endcase
      dacc_in = csr_wr_en ? csr_wr_data : dacc_ff;
      cacc_in = (accept && req_mode == MODE_SET_ACC) ? req_argument : cacc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dacc_ff <= DEFAULT_ACCEL_RESET;
         cacc_ff <= '0;
      end else begin
         dacc_ff <= dacc_in;
         cacc_ff <= cacc_in;
      end
   end

   gmte_lane #(.FRAC_BITS(FRAC_BITS)) u_lane0 (
      .clock(clock), .reset(reset), .start(accept && ctl.need0),
      .req(lreq0), .done(done0), .result(res0)
   );

   gmte_lane #(.FRAC_BITS(FRAC_BITS)) u_lane1 (
      .clock(clock), .reset(reset), .start(accept && ctl.need1),
      .req(lreq1), .done(done1), .result(res1)
   );

   gmte_merge u_merge (
      .clock(clock), .reset(reset), .start(accept), .ctl(ctl),
      .done0(done0), .res0(res0), .done1(done1), .res1(res1), .busy(busy),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_total_time(rsp_total_time), .rsp_item_time(rsp_item_time),
      .rsp_zero_speed(rsp_zero_speed)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready) else $error("accepted while a transaction is in flight");

   a_zero_speed_sat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_zero_speed) |-> (rsp_item_time == WORD_MAX))
      else $error("zero feed without saturated item time");

   a_total_covers_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_total_time >= TotalWidth'(rsp_item_time)))
      else $error("total below item time");
endmodule
`default_nettype wire
